// ===== rtl/core/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared types and constants for the streaming bounding-box unit.
// ----------------------------------------------------------------------------
package aabb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT,
    ST_HOLD
  } aabb_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } aabb_sqrt_stat_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

// ===== rtl/core/aabb_stream_with_radius_unit.sv =====
// ----------------------------------------------------------------------------
// aabb_stream_with_radius_unit
// Streaming axis-aligned bounding box with conservative radius per mesh.
// ----------------------------------------------------------------------------
//   channel | signals                        | transfer when
//   --------+--------------------------------+------------------------------
//   in      | pos_x/y/z, last_vertex         | in_valid_i & in_ready_o
//   out     | min_x/y/z, max_x/y/z, radius   | out_valid_o & out_ready_i
//
// A vertex without the last mark only updates the box; the sequencer stays idle and ready.
// A last vertex runs the radius sequence: the shared multiplier squares each of the
// three axes in turn, then the one-bit-per-cycle root runs over the sum.
// The result sits in an output register; the next mesh may start while it waits.
// Reset needs no clearing pass; the box is seeded by the first vertex of a mesh.
// A stalled output only holds the sequencer once the next radius is ready.
// ----------------------------------------------------------------------------
module aabb_stream_with_radius_unit #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS-1:0] pos_z_i,
  input  logic                         last_vertex_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] min_x_o,
  output logic signed [COORD_BITS-1:0] min_y_o,
  output logic signed [COORD_BITS-1:0] min_z_o,
  output logic signed [COORD_BITS-1:0] max_x_o,
  output logic signed [COORD_BITS-1:0] max_y_o,
  output logic signed [COORD_BITS-1:0] max_z_o,
  output logic        [COORD_BITS-1:0] radius_o
);

  localparam int unsigned SumW = 2 * COORD_BITS;

  aabb_pkg::aabb_state_e     state_q, state_d;
  aabb_pkg::aabb_sqrt_stat_t sq_stat;

  logic                         in_fire;
  logic                         mesh_start_q, mesh_start_d;
  logic [1:0]                   axis_q, axis_d;
  logic signed [COORD_BITS-1:0] pos   [3];
  logic signed [COORD_BITS-1:0] low   [3];
  logic signed [COORD_BITS-1:0] high  [3];
  logic [COORD_BITS-1:0]        mag;
  logic [COORD_BITS-1:0]        root;
  logic [SumW-1:0]              prod_q;
  logic [SumW-1:0]              sum_q, sum_d;
  logic                         sq_start;
  logic                         out_free;
  logic                         out_load;
  logic                         out_valid_q, out_valid_d;
  logic signed [COORD_BITS-1:0] out_low_q  [3];
  logic signed [COORD_BITS-1:0] out_high_q [3];
  logic [COORD_BITS-1:0]        out_radius_q;

  assign pos[0]  = pos_x_i;
  assign pos[1]  = pos_y_i;
  assign pos[2]  = pos_z_i;
  assign in_fire = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  aabb_box #(
    .COORD_BITS(COORD_BITS)
  ) u_box (
    .clk_i  (clk_i),
    .upd_i  (in_fire),
    .seed_i (mesh_start_q),
    .pos_i  (pos),
    .axis_i (axis_q),
    .low_o  (low),
    .high_o (high),
    .mag_o  (mag)
  );

  aabb_isqrt #(
    .COORD_BITS(COORD_BITS)
  ) u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sum_d),
    .stat_o     (sq_stat),
    .root_o     (root)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aabb_pkg::ST_IDLE: begin
        if (in_fire && last_vertex_i) begin
          state_d = aabb_pkg::ST_SQUARE;
        end
      end
      aabb_pkg::ST_SQUARE: begin
        state_d = aabb_pkg::ST_ACCUM;
      end
      aabb_pkg::ST_ACCUM: begin
        state_d = (axis_q == aabb_pkg::AXIS_Z) ? aabb_pkg::ST_ROOT : aabb_pkg::ST_SQUARE;
      end
      aabb_pkg::ST_ROOT: begin
        if (sq_stat.done) begin
          state_d = out_free ? aabb_pkg::ST_IDLE : aabb_pkg::ST_HOLD;
        end
      end
      aabb_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = aabb_pkg::ST_IDLE;
        end
      end
      default: state_d = aabb_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o   = 1'b0;
    sq_start     = 1'b0;
    out_load     = 1'b0;
    axis_d       = axis_q;
    sum_d        = sum_q;
    mesh_start_d = mesh_start_q;
    unique case (state_q)
      aabb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire) begin
          mesh_start_d = last_vertex_i;
          axis_d       = aabb_pkg::AXIS_X;
          sum_d        = '0;
        end
      end
      aabb_pkg::ST_SQUARE: begin
      end
      aabb_pkg::ST_ACCUM: begin
        sum_d = sum_q + prod_q;
        if (axis_q == aabb_pkg::AXIS_Z) begin
          sq_start = 1'b1;
        end else begin
          axis_d = axis_q + 1'b1;
        end
      end
      aabb_pkg::ST_ROOT: begin
        out_load = sq_stat.done && out_free;
      end
      aabb_pkg::ST_HOLD: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= aabb_pkg::ST_IDLE;
      mesh_start_q <= 1'b1;
      axis_q       <= aabb_pkg::AXIS_X;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      mesh_start_q <= mesh_start_d;
      axis_q       <= axis_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {{COORD_BITS{1'b0}}, mag} * {{COORD_BITS{1'b0}}, mag};
    sum_q  <= sum_d;
    if (out_load) begin
      out_low_q    <= low;
      out_high_q   <= high;
      out_radius_q <= root;
    end
  end

  assign out_valid_o = out_valid_q;
  assign min_x_o     = out_low_q[0];
  assign min_y_o     = out_low_q[1];
  assign min_z_o     = out_low_q[2];
  assign max_x_o     = out_high_q[0];
  assign max_y_o     = out_high_q[1];
  assign max_z_o     = out_high_q[2];
  assign radius_o    = out_radius_q;

  a_root_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_stat.done |-> state_q == aabb_pkg::ST_ROOT)
    else $error("root finished outside root state");

  a_last_starts_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_vertex_i) |=> state_q == aabb_pkg::ST_SQUARE)
    else $error("last vertex did not start radius sequence");

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mesh_start_q |-> (low[0] <= high[0]) && (low[1] <= high[1]) && (low[2] <= high[2]))
    else $error("box minimum above maximum");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before transfer");

endmodule

// ===== rtl/core/aabb_box.sv =====
// ----------------------------------------------------------------------------
// aabb_box
// Per-axis minimum and maximum registers with the larger-magnitude select.
// ----------------------------------------------------------------------------
module aabb_box #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         upd_i,
  input  logic                         seed_i,
  input  logic signed [COORD_BITS-1:0] pos_i  [3],
  input  logic        [1:0]            axis_i,
  output logic signed [COORD_BITS-1:0] low_o  [3],
  output logic signed [COORD_BITS-1:0] high_o [3],
  output logic        [COORD_BITS-1:0] mag_o
);

  logic signed [COORD_BITS-1:0] low_q  [3];
  logic signed [COORD_BITS-1:0] low_d  [3];
  logic signed [COORD_BITS-1:0] high_q [3];
  logic signed [COORD_BITS-1:0] high_d [3];
  logic signed [COORD_BITS-1:0] sel_low;
  logic signed [COORD_BITS-1:0] sel_high;
  logic        [COORD_BITS-1:0] mag_low;
  logic        [COORD_BITS-1:0] mag_high;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      low_d[a]  = low_q[a];
      high_d[a] = high_q[a];
      if (seed_i || (pos_i[a] < low_q[a])) begin
        low_d[a] = pos_i[a];
      end
      if (seed_i || (pos_i[a] > high_q[a])) begin
        high_d[a] = pos_i[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      for (int a = 0; a < 3; a++) begin
        low_q[a]  <= low_d[a];
        high_q[a] <= high_d[a];
      end
    end
  end

  always_comb begin
    unique case (axis_i)
      aabb_pkg::AXIS_X: begin
        sel_low  = low_q[0];
        sel_high = high_q[0];
      end
      aabb_pkg::AXIS_Y: begin
        sel_low  = low_q[1];
        sel_high = high_q[1];
      end
      aabb_pkg::AXIS_Z: begin
        sel_low  = low_q[2];
        sel_high = high_q[2];
      end
      default: begin
        sel_low  = '0;
        sel_high = '0;
      end
    endcase
  end

  assign mag_low  = sel_low[COORD_BITS-1]  ? (~sel_low + 1'b1)  : sel_low;
  assign mag_high = sel_high[COORD_BITS-1] ? (~sel_high + 1'b1) : sel_high;
  assign mag_o    = (mag_low > mag_high) ? mag_low : mag_high;

  assign low_o  = low_q;
  assign high_o = high_q;

endmodule

// ===== rtl/core/aabb_isqrt.sv =====
// ----------------------------------------------------------------------------
// aabb_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module aabb_isqrt #(
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [2*COORD_BITS-1:0]       radicand_i,
  output aabb_pkg::aabb_sqrt_stat_t     stat_o,
  output logic [COORD_BITS-1:0]         root_o
);

  localparam int unsigned RadW = 2 * COORD_BITS;
  localparam int unsigned RemW = COORD_BITS + 3;
  localparam int unsigned CntW = $clog2(COORD_BITS + 1);

  logic [RadW-1:0]       rad_q;
  logic [RemW-1:0]       rem_q;
  logic [RemW-1:0]       rem_sh;
  logic [RemW-1:0]       trial;
  logic                  ge;
  logic [COORD_BITS-1:0] root_q;
  logic [CntW-1:0]       cnt_q;
  logic                  busy_q;
  logic                  done_q;

  assign rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(COORD_BITS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RadW-3:0], 2'b00};
      rem_q  <= ge ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[COORD_BITS-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule
